// File: src/tgct_pkg.sv
// Shared types, constants and codes for the tilt gesture cursor tracker.
package tgct_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [16:0] CURSOR_ONE    = 17'd65536;
  localparam logic [16:0] CURSOR_CENTRE = 17'd32768;
  localparam logic [12:0] WIDTH_MAX     = 13'd4096;

  typedef enum logic [1:0] {
    CMD_UPDATE    = 2'd0,
    CMD_CALIBRATE = 2'd1,
    CMD_RECENTER  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_DEADBAND    = 2'd0,
    CFG_SENSITIVITY = 2'd1,
    CFG_IDLE_LIMIT  = 2'd2,
    CFG_PIX_WIDTH   = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    DIR_NONE  = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_LEFT  = 2'd2
  } dir_e;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [15:0] accel_x;
    logic [15:0]        time_step;
    logic               sample_present;
  } in_item_t;

  typedef struct packed {
    logic [16:0] cursor_pos;
    logic [11:0] pixel_col;
    logic        gesture_phase;
    logic [1:0]  gesture_dir;
    logic        moved;
  } out_item_t;

  typedef struct packed {
    logic [14:0] deadband;
    logic [15:0] sensitivity;
    logic [7:0]  idle_limit;
    logic [12:0] pix_width;
  } cfg_t;

  // One classified request as handed from the front to the back.
  typedef struct packed {
    logic        center;
    logic        sample;
    logic [1:0]  dir;
    logic [15:0] mag;
    logic [15:0] dt;
  } op_t;

endpackage

// File: src/tgct_front.sv
// Front end: takes requests, tracks calibration and classifies each sample.
module tgct_front
  import tgct_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  in_item_t item_i,
  input  cfg_t     cfg_i,
  output op_t      op_o
);

  logic signed [15:0] bias_q, bias_d;
  logic               calibrated_q, calibrated_d;
  logic               is_cal, is_sample, auto_cal;
  logic signed [15:0] bias_use;
  logic signed [16:0] diff;
  logic [16:0]        abs_diff;
  logic [15:0]        mag;
  logic               in_zone;

  always_comb begin
    is_cal    = (item_i.command == CMD_CALIBRATE);
    is_sample = (item_i.command == CMD_UPDATE) && (item_i.time_step != 16'd0)
                && item_i.sample_present;
    auto_cal  = is_sample && !calibrated_q;
    // An uncalibrated sample calibrates from itself, so its difference is zero.
    bias_use  = calibrated_q ? bias_q : item_i.accel_x;
    diff      = {item_i.accel_x[15], item_i.accel_x} - {bias_use[15], bias_use};
    abs_diff  = diff[16] ? (17'd0 - diff) : diff;
    mag       = abs_diff[15:0];
    in_zone   = (mag < {1'b0, cfg_i.deadband});

    op_o.center = is_cal || auto_cal || (item_i.command == CMD_RECENTER);
    op_o.sample = is_sample;
    op_o.mag    = in_zone ? 16'd0 : mag;
    op_o.dt     = item_i.time_step;
    if (in_zone || diff == 17'sd0) begin
      op_o.dir = DIR_NONE;
    end else if (diff[16]) begin
      op_o.dir = DIR_LEFT;
    end else begin
      op_o.dir = DIR_RIGHT;
    end

    bias_d       = bias_q;
    calibrated_d = calibrated_q;
    if (push_i && (is_cal || auto_cal)) begin
      bias_d       = item_i.accel_x;
      calibrated_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_q       <= '0;
      calibrated_q <= 1'b0;
    end else begin
      bias_q       <= bias_d;
      calibrated_q <= calibrated_d;
    end
  end

endmodule

// File: src/tgct_queue.sv
// Small register queue between the front and the back.
module tgct_queue
  import tgct_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  op_i,
  input  logic pop_i,
  output op_t  op_o,
  output logic empty_o,
  output logic full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  op_t             entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  always_comb begin
    empty_o  = (count_q == '0);
    full_o   = (count_q == CntW'(Depth));
    op_o     = entry_q[rd_ptr_q];
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= op_i;
    end
  end

endmodule

// File: src/tgct_back.sv
// Back end: gesture machine, cursor update with sequenced multiplies, result register.
module tgct_back
  import tgct_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  op_t       op_i,
  input  logic      empty_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL1 = 6'b000010,
    S_MUL2 = 6'b000100,
    S_STEP = 6'b001000,
    S_PIX  = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  state_e      state_q, state_d;
  logic        phase_q, phase_d;
  logic [1:0]  dir_q, dir_d;
  logic [7:0]  idle_q, idle_d;
  logic [16:0] cursor_q, cursor_d;
  logic        moved_q, moved_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;

  logic [15:0] mag_q, dt_q;
  logic [1:0]  mdir_q;
  logic [31:0] prod1_q;
  logic [47:0] prod2_q;
  logic [29:0] pix_q;

  logic [7:0]  limit, idle_inc;
  logic        take, out_free;
  logic [48:0] rounded;
  logic [24:0] step;
  logic [25:0] sum;
  logic [12:0] w_eff;
  logic [13:0] pix_raw;
  logic [11:0] pix_col;

  always_comb begin
    limit    = (cfg_i.idle_limit == 8'd0) ? 8'd1 : cfg_i.idle_limit;
    idle_inc = (idle_q == 8'hFF) ? idle_q : idle_q + 8'd1;
    w_eff    = (cfg_i.pix_width > WIDTH_MAX) ? WIDTH_MAX : cfg_i.pix_width;
    rounded  = {1'b0, prod2_q} + 49'h000_0080_0000;
    step     = rounded[48:24];
    sum      = {9'd0, cursor_q} + {1'b0, step};
    pix_raw  = pix_q[29:16];
    if (w_eff == 13'd0) begin
      pix_col = '0;
    end else if (pix_raw >= {1'b0, w_eff}) begin
      pix_col = 12'(w_eff - 13'd1);
    end else begin
      pix_col = pix_raw[11:0];
    end
    out_free = !out_valid_q || !out_stall_i;
    take     = (state_q == S_IDLE) && !empty_i;
    pop_o    = take;
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    dir_d       = dir_q;
    idle_d      = idle_q;
    cursor_d    = cursor_q;
    moved_d     = moved_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (take) begin
          moved_d = 1'b0;
          if (op_i.center) begin
            cursor_d = CURSOR_CENTRE;
          end
          if (op_i.sample) begin
            if (!phase_q) begin
              if (op_i.dir != DIR_NONE) begin
                phase_d = 1'b1;
                dir_d   = op_i.dir;
                idle_d  = '0;
                moved_d = 1'b1;
              end
            end else if (op_i.dir == DIR_NONE) begin
              idle_d = idle_inc;
              if (idle_inc >= limit) begin
                phase_d = 1'b0;
                dir_d   = DIR_NONE;
                idle_d  = '0;
              end
            end else if (op_i.dir == dir_q) begin
              idle_d  = '0;
              moved_d = 1'b1;
            end else begin
              idle_d = '0;
            end
          end
          state_d = (op_i.sample && phase_d && op_i.dir == dir_d && !phase_q)
                    || (op_i.sample && phase_q && op_i.dir != DIR_NONE
                        && op_i.dir == dir_q) ? S_MUL1 : S_PIX;
        end
      end
      S_MUL1: state_d = S_MUL2;
      S_MUL2: state_d = S_STEP;
      S_STEP: begin
        if (mdir_q == DIR_RIGHT) begin
          cursor_d = (sum > {9'd0, CURSOR_ONE}) ? CURSOR_ONE : sum[16:0];
        end else begin
          cursor_d = (step >= {8'd0, cursor_q}) ? 17'd0 : cursor_q - step[16:0];
        end
        state_d = S_PIX;
      end
      S_PIX: state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          out_d.cursor_pos    = cursor_q;
          out_d.pixel_col     = pix_col;
          out_d.gesture_phase = phase_q;
          out_d.gesture_dir   = dir_q;
          out_d.moved         = moved_q;
          out_valid_d         = 1'b1;
          state_d             = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= 1'b0;
      dir_q       <= DIR_NONE;
      idle_q      <= '0;
      cursor_q    <= CURSOR_CENTRE;
      moved_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      dir_q       <= dir_d;
      idle_q      <= idle_d;
      cursor_q    <= cursor_d;
      moved_q     <= moved_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers: the operands are captured when a request is taken,
  // then the two products, the cursor step and the pixel product are formed in that order.
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (take) begin
      mag_q  <= op_i.mag;
      dt_q   <= op_i.dt;
      mdir_q <= op_i.dir;
    end
    if (state_q == S_MUL1) begin
      prod1_q <= mag_q * cfg_i.sensitivity;
    end
    if (state_q == S_MUL2) begin
      prod2_q <= prod1_q * dt_q;
    end
    if (state_q == S_PIX) begin
      pix_q <= cursor_q * w_eff;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: src/tilt_gesture_cursor_tracker_top.sv
// Top level of the tilt gesture cursor tracker: configuration registers and wiring.
//
//   channel  direction  handshake                 payload
//   in       request in in_valid_i / in_stall_o   in_data_i  (in_item_t)
//   out      result out out_valid_o / out_stall_i out_data_o (out_item_t)
//   cfg      write in   cfg_we_i, cfg_idx_i       cfg_wdata_i
//
// A request that moves the cursor passes through the back end states in order (take, two
// multiplies, step and saturate, pixel multiply, result); any other request goes from take
// straight to pixel multiply and result. The single shared back end handles one request at a
// time; the queue lets the front keep taking requests while a result waits under stall.
// Reset loads the configuration defaults, clears calibration and the gesture state and centers the cursor.
module tilt_gesture_cursor_tracker_top
  import tgct_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o,
  input  logic      cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  cfg_t cfg_q, cfg_d;
  op_t  front_op, queue_op;
  logic push, pop, q_empty, q_full;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEADBAND:    cfg_d.deadband    = cfg_wdata_i[14:0];
        CFG_SENSITIVITY: cfg_d.sensitivity = cfg_wdata_i;
        CFG_IDLE_LIMIT:  cfg_d.idle_limit  = cfg_wdata_i[7:0];
        CFG_PIX_WIDTH:   cfg_d.pix_width   = cfg_wdata_i[12:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.deadband    <= 15'd38;
      cfg_q.sensitivity <= 16'd13107;
      cfg_q.idle_limit  <= 8'd45;
      cfg_q.pix_width   <= 13'd1024;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign in_stall_o = q_full;
  assign push       = in_valid_i && !q_full;

  tgct_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (in_data_i),
    .cfg_i  (cfg_q),
    .op_o   (front_op)
  );

  tgct_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (front_op),
    .pop_i   (pop),
    .op_o    (queue_op),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  tgct_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .op_i        (queue_op),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: src/tgct_checker.sv
// Port-level checks for the tilt gesture cursor tracker, bound to the top level.
module tgct_checker
  import tgct_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result payload changed while stalled");

  // The cursor never leaves the range zero to one.
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.cursor_pos <= CURSOR_ONE)
    else $error("cursor out of range");

  // A direction is locked exactly while a gesture is active.
  a_phase_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.gesture_phase == (out_data_o.gesture_dir != DIR_NONE))
                    && (out_data_o.gesture_dir == DIR_NONE
                        || out_data_o.gesture_dir == DIR_RIGHT
                        || out_data_o.gesture_dir == DIR_LEFT))
    else $error("gesture phase and direction disagree");

  // The cursor only moves inside an active gesture.
  a_moved_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.moved |-> out_data_o.gesture_phase)
    else $error("cursor moved outside a gesture");

endmodule

bind tilt_gesture_cursor_tracker_top tgct_checker u_tgct_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
